[hdl/occ_pkg.sv]
// Shared types and constants for the occupancy grid projection block.
package occ_pkg;

  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_OBST = 3'd1,
    OP_FREE = 3'd2,
    OP_SKIP = 3'd3,
    OP_DISK = 3'd4,
    OP_READ = 3'd5
  } op_t;

  localparam logic [1:0] KIND_VOXEL = 2'd0;
  localparam logic [1:0] KIND_DISK  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE    = 3'd2;
  localparam logic [2:0] REG_GROUND_LEVEL = 3'd3;
  localparam logic [2:0] REG_HEIGHT_LIMIT = 3'd4;
  localparam logic [2:0] REG_MIN_HITS     = 3'd5;
  localparam logic [2:0] REG_COLS_USED    = 3'd6;
  localparam logic [2:0] REG_ROWS_USED    = 3'd7;

  localparam logic [7:0] PIX_OCC     = 8'd0;
  localparam logic [7:0] PIX_FREE    = 8'd254;
  localparam logic [7:0] PIX_UNKNOWN = 8'd205;

  localparam int NUM_W = 34;
  localparam int DEN_W = 17;
  localparam int CLR_W = 17;

  typedef struct packed {
    logic signed [31:0] grid_x0;
    logic signed [31:0] grid_y0;
    logic [15:0]        cell_size;
    logic signed [31:0] ground_level;
    logic signed [31:0] height_limit;
    logic [15:0]        min_hits;
    logic [8:0]         cols_used;
    logic [8:0]         rows_used;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [23:0]        ext;
    logic [7:0]         row;
    logic [7:0]         col;
  } item_t;

endpackage

[hdl/occ_front.sv]
// Front end: item classification and a two-entry queue toward the back end.
module occ_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hold,
  input  occ_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic [23:0]          extent,
  input  logic                 occupied,
  input  logic [7:0]           read_row,
  input  logic [7:0]           read_col,
  output logic                 q_valid,
  output occ_pkg::item_t       q_item,
  input  logic                 q_pop
);

  occ_pkg::item_t slots [2];
  occ_pkg::item_t cur;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;
  logic           push;

  always_comb begin
    cur.x   = pos_x;
    cur.y   = pos_y;
    cur.ext = extent;
    cur.row = read_row;
    cur.col = read_col;
    unique case (kind)
      occ_pkg::KIND_VOXEL: begin
        if (occupied && pos_z > cfg.height_limit) begin
          cur.op = occ_pkg::OP_SKIP;
        end else if (occupied && !(pos_z < cfg.ground_level)) begin
          cur.op = occ_pkg::OP_OBST;
        end else begin
          cur.op = occ_pkg::OP_FREE;
        end
      end
      occ_pkg::KIND_DISK: cur.op = occ_pkg::OP_DISK;
      occ_pkg::KIND_READ: cur.op = occ_pkg::OP_READ;
      default:            cur.op = occ_pkg::OP_NOP;
    endcase
  end

  assign in_ready = !hold && (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 2'd1;
    end else if (!push && q_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cur;
    end
  end

endmodule

[hdl/occ_div.sv]
// Restoring divider, one quotient bit per cycle, non-negative operands.
module occ_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [occ_pkg::NUM_W-1:0]   num,
  input  logic [occ_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [occ_pkg::NUM_W-1:0]   quot
);

  localparam int CNT_W = $clog2(occ_pkg::NUM_W + 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [occ_pkg::NUM_W-1:0]   sh;
  logic [occ_pkg::DEN_W-1:0]   rem;
  logic [occ_pkg::DEN_W:0]     trial;
  logic                        qbit;
  logic [occ_pkg::DEN_W-1:0]   rem_next;

  assign trial    = {rem, sh[occ_pkg::NUM_W-1]};
  assign qbit     = trial >= {1'b0, den};
  assign rem_next = qbit ? occ_pkg::DEN_W'(trial - {1'b0, den}) : trial[occ_pkg::DEN_W-1:0];
  assign quot     = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(occ_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= num;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[occ_pkg::NUM_W-2:0], qbit};
      rem <= rem_next;
    end
  end

endmodule

[hdl/occ_back.sv]
// Back end: bound division, cell walk with read-modify-write, count memory, result register.
module occ_back #(
  parameter int GRID_COLS  = 256,
  parameter int GRID_ROWS  = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  occ_pkg::cfg_t        cfg,
  input  logic                 q_valid,
  input  occ_pkg::item_t       q_item,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           pixel,
  output logic [16:0]          cleared_cells,
  output logic                 skipped
);

  localparam int CW    = $clog2(GRID_COLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int WW    = 2 * COUNT_BITS;
  localparam int DW    = 36;
  localparam int NW    = occ_pkg::NUM_W;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DSTART = 9'b000000100,
    S_DWAIT  = 9'b000001000,
    S_SETUP  = 9'b000010000,
    S_BASE   = 9'b000100000,
    S_RD     = 9'b001000000,
    S_WR     = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  occ_pkg::item_t          it;
  logic [1:0]              sel;
  logic [3:0]              bneg;
  logic [NW-1:0]           bq [4];
  logic [CW-1:0]           c_lo, c_hi, c;
  logic [RW-1:0]           r_hi, r;
  logic [AW-1:0]           addr, row_base, clr_addr;
  logic [CW+15:0]          prod_c;
  logic [RW+15:0]          prod_r;
  logic signed [DW-1:0]    dx, dy, dx0;
  logic [49:0]             lim;
  logic [51:0]             sqx, sqy;
  logic                    inx, iny;
  logic [occ_pkg::CLR_W-1:0] cnt;
  logic [7:0]              res_pixel;
  logic                    res_skip;

  logic [WW-1:0]           mem [CELLS];
  logic [WW-1:0]           rdata;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [WW-1:0]           wdata;

  logic [15:0]             cs_eff;
  logic signed [DW-1:0]    cs2;
  logic [CW-1:0]           col_max;
  logic [RW-1:0]           row_max;
  logic                    div_start, div_done;
  logic [NW-1:0]           div_quot;
  logic signed [NW:0]      p2, o2, ev, num;
  logic [CW-1:0]           clo, chi;
  logic [RW-1:0]           rlo, rhi;
  logic                    empty;
  logic [24:0]             rad2;
  logic [DW-1:0]           adx, ady;
  logic                    in_disk;
  logic [COUNT_BITS-1:0]   obs, fr;
  logic                    last_sel;

  assign clearing = (state == S_CLEAR);
  assign cs_eff   = (cfg.cell_size == 16'd0) ? 16'd1 : cfg.cell_size;
  assign cs2      = DW'({cs_eff, 1'b0});
  assign rad2     = {it.ext, 1'b0};
  assign last_sel = (sel == 2'd3);

  always_comb begin
    if (cfg.cols_used == 9'd0) begin
      col_max = '0;
    end else if (32'(cfg.cols_used) > GRID_COLS) begin
      col_max = CW'(GRID_COLS - 1);
    end else begin
      col_max = CW'(cfg.cols_used - 9'd1);
    end
    if (cfg.rows_used == 9'd0) begin
      row_max = '0;
    end else if (32'(cfg.rows_used) > GRID_ROWS) begin
      row_max = RW'(GRID_ROWS - 1);
    end else begin
      row_max = RW'(cfg.rows_used - 9'd1);
    end
  end

  always_comb begin
    p2  = sel[1] ? {{2{it.y[31]}}, it.y, 1'b0} : {{2{it.x[31]}}, it.x, 1'b0};
    o2  = sel[1] ? {{2{cfg.grid_y0[31]}}, cfg.grid_y0, 1'b0}
                 : {{2{cfg.grid_x0[31]}}, cfg.grid_x0, 1'b0};
    ev  = (it.op == occ_pkg::OP_DISK) ? (NW+1)'({it.ext, 1'b0}) : (NW+1)'(it.ext);
    num = sel[0] ? (p2 + ev - o2) : (p2 - ev - o2);
  end

  occ_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num[NW-1:0]),
    .den   ({cs_eff, 1'b0}),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    clo = bneg[0] ? '0 : ((bq[0] > NW'(col_max)) ? col_max : CW'(bq[0]));
    chi = bneg[1] ? '0 : ((bq[1] > NW'(col_max)) ? col_max : CW'(bq[1]));
    rlo = bneg[2] ? '0 : ((bq[2] > NW'(row_max)) ? row_max : RW'(bq[2]));
    rhi = bneg[3] ? '0 : ((bq[3] > NW'(row_max)) ? row_max : RW'(bq[3]));
    empty = (!bneg[0] && bq[0] > NW'(col_max)) || bneg[1] ||
            (!bneg[2] && bq[2] > NW'(row_max)) || bneg[3];
  end

  assign adx     = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady     = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign obs     = rdata[WW-1:COUNT_BITS];
  assign fr      = rdata[COUNT_BITS-1:0];
  assign in_disk = inx && iny && ({1'b0, sqx} + {1'b0, sqy} <= 53'(lim));

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    we         = 1'b0;
    waddr      = addr;
    wdata      = rdata;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == AW'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op) inside
            occ_pkg::OP_OBST, occ_pkg::OP_FREE, occ_pkg::OP_DISK: state_next = S_DSTART;
            occ_pkg::OP_READ: begin
              if (32'(q_item.row) > 32'(row_max) || 32'(q_item.col) > 32'(col_max)) begin
                state_next = S_DONE;
              end else begin
                state_next = S_RD;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_DSTART: begin
        if (num[NW]) begin
          if (last_sel) begin
            state_next = S_SETUP;
          end
        end else begin
          div_start  = 1'b1;
          state_next = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          state_next = last_sel ? S_SETUP : S_DSTART;
        end
      end
      S_SETUP: begin
        state_next = (it.op == occ_pkg::OP_DISK && empty) ? S_DONE : S_BASE;
      end
      S_BASE: state_next = S_RD;
      S_RD:   state_next = S_WR;
      S_WR: begin
        case (it.op)
          occ_pkg::OP_OBST: begin
            we    = 1'b1;
            wdata = {(obs == CMAX) ? obs : obs + COUNT_BITS'(1), fr};
          end
          occ_pkg::OP_FREE: begin
            we    = 1'b1;
            wdata = {obs, (fr == CMAX) ? fr : fr + COUNT_BITS'(1)};
          end
          occ_pkg::OP_DISK: begin
            we    = in_disk;
            wdata = {{COUNT_BITS{1'b0}}, (fr == '0) ? COUNT_BITS'(1) : fr};
          end
          default: we = 1'b0;
        endcase
        if (it.op == occ_pkg::OP_READ || (c == c_hi && r == r_hi)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      pixel         <= res_pixel;
      cleared_cells <= cnt;
      skipped       <= res_skip;
    end
    case (state)
      S_IDLE: begin
        it        <= q_item;
        sel       <= 2'd0;
        cnt       <= '0;
        res_skip  <= (q_item.op == occ_pkg::OP_SKIP);
        res_pixel <= (q_item.op == occ_pkg::OP_READ) ? occ_pkg::PIX_UNKNOWN : 8'd0;
        addr      <= AW'(32'(q_item.row) * GRID_COLS + 32'(q_item.col));
      end
      S_DSTART: begin
        if (num[NW]) begin
          bneg[sel] <= 1'b1;
          bq[sel]   <= '0;
          sel       <= sel + 2'd1;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          bneg[sel] <= 1'b0;
          bq[sel]   <= div_quot;
          sel       <= sel + 2'd1;
        end
      end
      S_SETUP: begin
        c_lo     <= clo;
        c_hi     <= chi;
        c        <= clo;
        r        <= rlo;
        r_hi     <= rhi;
        prod_c   <= clo * cs_eff;
        prod_r   <= rlo * cs_eff;
        lim      <= rad2 * rad2;
        row_base <= AW'(32'(rlo) * GRID_COLS);
      end
      S_BASE: begin
        dx   <= DW'($signed({cfg.grid_x0, 1'b0})) - DW'($signed({it.x, 1'b0}))
                + DW'(cs_eff) + DW'({prod_c, 1'b0});
        dx0  <= DW'($signed({cfg.grid_x0, 1'b0})) - DW'($signed({it.x, 1'b0}))
                + DW'(cs_eff) + DW'({prod_c, 1'b0});
        dy   <= DW'($signed({cfg.grid_y0, 1'b0})) - DW'($signed({it.y, 1'b0}))
                + DW'(cs_eff) + DW'({prod_r, 1'b0});
        addr <= row_base + AW'(c_lo);
      end
      S_RD: begin
        inx <= adx <= DW'(rad2);
        iny <= ady <= DW'(rad2);
        sqx <= adx[25:0] * adx[25:0];
        sqy <= ady[25:0] * ady[25:0];
      end
      S_WR: begin
        if (it.op == occ_pkg::OP_READ) begin
          if (32'(obs) >= 32'(cfg.min_hits)) begin
            res_pixel <= occ_pkg::PIX_OCC;
          end else if (fr != '0) begin
            res_pixel <= occ_pkg::PIX_FREE;
          end else begin
            res_pixel <= occ_pkg::PIX_UNKNOWN;
          end
        end
        if (it.op == occ_pkg::OP_DISK && in_disk && obs != '0) begin
          cnt <= cnt + occ_pkg::CLR_W'(1);
        end
        if (c == c_hi) begin
          r        <= r + RW'(1);
          c        <= c_lo;
          dx       <= dx0;
          dy       <= dy + cs2;
          row_base <= row_base + AW'(GRID_COLS);
          addr     <= row_base + AW'(GRID_COLS) + AW'(c_lo);
        end else begin
          c    <= c + CW'(1);
          dx   <= dx + cs2;
          addr <= addr + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/voxel_to_occupancy_grid.sv]
// Top level: configuration registers, front end and back end of the occupancy grid projection.
// Paths: a read on the grid passes through the memory read and write states; a skipped voxel,
// unknown kind or read off the grid goes straight to the result; a voxel or disk first runs a
// divider pass per bound (none for a bound below zero), then setup and base address, then its
// cells, one memory read then write each; an empty disk walks no cells. The back end takes one
// item at a time. Reset: synchronous; registers return to defaults and a clearing pass over all
// GRID_COLS * GRID_ROWS cells zeroes the counts, with no item accepted meanwhile.
module voxel_to_occupancy_grid #(
  parameter int GRID_COLS  = 256,
  parameter int GRID_ROWS  = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic [23:0]          extent,
  input  logic                 occupied,
  input  logic [7:0]           read_row,
  input  logic [7:0]           read_col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           pixel,
  output logic [16:0]          cleared_cells,
  output logic                 skipped
);

  occ_pkg::cfg_t  cfg;
  occ_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;
  logic           clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_x0      <= 32'sd0;
      cfg.grid_y0      <= 32'sd0;
      cfg.cell_size    <= 16'd51;
      cfg.ground_level <= 32'sd102;
      cfg.height_limit <= 32'sd1024;
      cfg.min_hits     <= 16'd2;
      cfg.cols_used    <= 9'd256;
      cfg.rows_used    <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        occ_pkg::REG_ORIGIN_X:     cfg.grid_x0      <= cfg_data;
        occ_pkg::REG_ORIGIN_Y:     cfg.grid_y0      <= cfg_data;
        occ_pkg::REG_CELL_SIZE:    cfg.cell_size    <= cfg_data[15:0];
        occ_pkg::REG_GROUND_LEVEL: cfg.ground_level <= cfg_data;
        occ_pkg::REG_HEIGHT_LIMIT: cfg.height_limit <= cfg_data;
        occ_pkg::REG_MIN_HITS:     cfg.min_hits     <= cfg_data[15:0];
        occ_pkg::REG_COLS_USED:    cfg.cols_used    <= cfg_data[8:0];
        occ_pkg::REG_ROWS_USED:    cfg.rows_used    <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  occ_front u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (clearing),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .extent   (extent),
    .occupied (occupied),
    .read_row (read_row),
    .read_col (read_col),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  occ_back #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel         (pixel),
    .cleared_cells (cleared_cells),
    .skipped       (skipped)
  );

endmodule

[hdl/occ_checker.sv]
// Port-level checks for the occupancy grid projection block, bound to the top level.
module occ_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  pixel,
  input logic [16:0] cleared_cells,
  input logic        skipped
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(cleared_cells))
    else $error("stalled item changed");

  a_pixel_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel == 8'd0 || pixel == 8'd254 || pixel == 8'd205)
    else $error("bad pixel code");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel != 8'd0 |-> cleared_cells == 17'd0 && !skipped)
    else $error("read item carries other fields");

  a_skip_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && skipped |-> cleared_cells == 17'd0 && pixel == 8'd0)
    else $error("skipped item carries other fields");

endmodule

bind voxel_to_occupancy_grid occ_checker u_occ_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pixel         (pixel),
  .cleared_cells (cleared_cells),
  .skipped       (skipped)
);

[tb/sv/occ_grid_checker.sv]
// Checker for the occupancy grid: tracks registers and cell counts, predicts and compares results.
`timescale 1ns / 100ps
module occ_grid_checker
  import occ_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [23:0] extent,
  input  logic        occupied,
  input  logic [7:0]  read_row,
  input  logic [7:0]  read_col,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  pixel,
  input  logic [16:0] cleared_cells,
  input  logic        skipped,
  output int          pending_cnt,
  output int          fail_cnt
);

  localparam int NCOLS = 256;
  localparam int NROWS = 256;
  localparam logic [15:0] HITS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  pixel;
    logic [16:0] cleared;
    logic        skipped;
  } grid_result_t;

  grid_result_t expected_results[$];

  logic [15:0] obstacle_cnt [0:NCOLS*NROWS-1];
  logic [15:0] free_cnt [0:NCOLS*NROWS-1];

  longint org_x, org_y, ground_z, top_z;
  logic [15:0] cell_w, hits_needed;
  logic [8:0]  cols_in_use, rows_in_use;

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint cell_w_eff();
    return cell_w == 0 ? 1 : longint'(cell_w);
  endfunction

  function automatic longint cols_eff();
    return clip(longint'(cols_in_use), 1, NCOLS);
  endfunction

  function automatic longint rows_eff();
    return clip(longint'(rows_in_use), 1, NROWS);
  endfunction

  function automatic longint cell_at(longint n2, longint org);
    return floor_quot(n2 - 2 * org, 2 * cell_w_eff());
  endfunction

  function automatic void project_voxel(longint x, longint y, longint e, bit obst);
    longint c0, c1, r0, r1;
    int a;
    c0 = clip(cell_at(2 * x - e, org_x), 0, cols_eff() - 1);
    c1 = clip(cell_at(2 * x + e, org_x), 0, cols_eff() - 1);
    r0 = clip(cell_at(2 * y - e, org_y), 0, rows_eff() - 1);
    r1 = clip(cell_at(2 * y + e, org_y), 0, rows_eff() - 1);
    for (longint r = r0; r <= r1; r++) begin
      for (longint c = c0; c <= c1; c++) begin
        a = int'(r * NCOLS + c);
        if (obst) begin
          if (obstacle_cnt[a] != HITS_MAX) obstacle_cnt[a]++;
        end else begin
          if (free_cnt[a] != HITS_MAX) free_cnt[a]++;
        end
      end
    end
  endfunction

  function automatic logic [16:0] clear_disk(longint x, longint y, longint rad);
    longint cs, c0, c1, r0, r1, lim, dx, dy;
    int a;
    logic [16:0] n;
    cs = cell_w_eff();
    n = '0;
    c0 = cell_at(2 * (x - rad), org_x);
    c1 = cell_at(2 * (x + rad), org_x);
    r0 = cell_at(2 * (y - rad), org_y);
    r1 = cell_at(2 * (y + rad), org_y);
    lim = 4 * rad * rad;
    if (c0 < 0) c0 = 0;
    if (r0 < 0) r0 = 0;
    if (c1 > cols_eff() - 1) c1 = cols_eff() - 1;
    if (r1 > rows_eff() - 1) r1 = rows_eff() - 1;
    for (longint r = r0; r <= r1; r++) begin
      dy = 2 * org_y + (2 * r + 1) * cs - 2 * y;
      for (longint c = c0; c <= c1; c++) begin
        dx = 2 * org_x + (2 * c + 1) * cs - 2 * x;
        if (dx * dx + dy * dy <= lim) begin
          a = int'(r * NCOLS + c);
          if (obstacle_cnt[a] != 0) n++;
          obstacle_cnt[a] = '0;
          if (free_cnt[a] == 0) free_cnt[a] = 16'd1;
        end
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] read_pixel(logic [7:0] row, logic [7:0] col);
    int a;
    if (longint'(row) >= rows_eff() || longint'(col) >= cols_eff()) return PIX_UNKNOWN;
    a = int'(row) * NCOLS + int'(col);
    if (obstacle_cnt[a] >= hits_needed) return PIX_OCC;
    if (free_cnt[a] > 0) return PIX_FREE;
    return PIX_UNKNOWN;
  endfunction

  always @(posedge clk) begin
    grid_result_t want, got;
    longint z;
    if (rst) begin
      expected_results.delete();
      org_x = 0;
      org_y = 0;
      cell_w = 16'd51;
      ground_z = 102;
      top_z = 1024;
      hits_needed = 16'd2;
      cols_in_use = 9'd256;
      rows_in_use = 9'd256;
      for (int i = 0; i < NCOLS * NROWS; i++) begin
        obstacle_cnt[i] = '0;
        free_cnt[i] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        got = '{pixel, cleared_cells, skipped};
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: pixel %0d cleared %0d skipped %0d",
                   $time, pixel, cleared_cells, skipped);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got.pixel !== want.pixel) begin
            $display("%0t: pixel expected %0d actual %0d", $time, want.pixel, got.pixel);
            fail_cnt++;
          end
          if (got.cleared !== want.cleared) begin
            $display("%0t: cleared_cells expected %0d actual %0d",
                     $time, want.cleared, got.cleared);
            fail_cnt++;
          end
          if (got.skipped !== want.skipped) begin
            $display("%0t: skipped expected %0d actual %0d", $time, want.skipped, got.skipped);
            fail_cnt++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:     org_x = longint'($signed(cfg_data));
          REG_ORIGIN_Y:     org_y = longint'($signed(cfg_data));
          REG_CELL_SIZE:    cell_w = cfg_data[15:0];
          REG_GROUND_LEVEL: ground_z = longint'($signed(cfg_data));
          REG_HEIGHT_LIMIT: top_z = longint'($signed(cfg_data));
          REG_MIN_HITS:     hits_needed = cfg_data[15:0];
          REG_COLS_USED:    cols_in_use = cfg_data[8:0];
          REG_ROWS_USED:    rows_in_use = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = '0;
        z = longint'($signed(pos_z));
        case (kind)
          KIND_VOXEL: begin
            if (occupied && z > top_z) want.skipped = 1'b1;
            else project_voxel(longint'($signed(pos_x)), longint'($signed(pos_y)),
                               longint'(extent), occupied && !(z < ground_z));
          end
          KIND_DISK: want.cleared = clear_disk(longint'($signed(pos_x)),
                                               longint'($signed(pos_y)), longint'(extent));
          KIND_READ: want.pixel = read_pixel(read_row, read_col);
          default: ;
        endcase
        expected_results = {expected_results, want};
      end
    end
    pending_cnt = expected_results.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the occupancy grid: clock, reset, stimulus phases and verdict.
`timescale 1ns / 100ps
module tb_top;
  import occ_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [23:0] extent = '0;
  logic        occupied = 1'b0;
  logic [7:0]  read_row = '0, read_col = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel;
  logic [16:0] cleared_cells;
  logic        skipped;
  int          pending_cnt, fail_cnt;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  voxel_to_occupancy_grid i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .kind, .pos_x, .pos_y, .pos_z, .extent, .occupied, .read_row, .read_col,
    .out_valid, .out_ready, .pixel, .cleared_cells, .skipped
  );

  occ_grid_checker i_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .kind, .pos_x, .pos_y, .pos_z, .extent, .occupied, .read_row, .read_col,
    .out_valid, .out_ready, .pixel, .cleared_cells, .skipped, .pending_cnt, .fail_cnt
  );

  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // geometry of the current setting, used to aim items at the grid
  longint cur_ox, cur_oy, cur_cs, cur_gnd, cur_top;
  int     cur_cols, cur_rows;

  task automatic send_item(input logic [1:0] k, input logic [31:0] x, y, z,
                           input logic [23:0] e, input logic o,
                           input logic [7:0] r, c);
    kind <= k;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    extent <= e;
    occupied <= o;
    read_row <= r;
    read_col <= c;
    in_valid <= 1'b1;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic load_setting(input logic [31:0] ox, oy, input logic [15:0] cs,
                              input logic [31:0] gnd, top, input logic [15:0] hits,
                              input logic [8:0] cols, rows);
    logic [31:0] vals [8];
    in_valid <= 1'b0;
    wait (pending_cnt == 0);
    repeat (300) @(negedge clk);
    while (!in_ready) @(negedge clk);
    vals = '{ox, oy, 32'(cs), gnd, top, 32'(hits), 32'(cols), 32'(rows)};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_ox = longint'($signed(ox));
    cur_oy = longint'($signed(oy));
    cur_cs = cs == 0 ? 1 : longint'(cs);
    cur_gnd = longint'($signed(gnd));
    cur_top = longint'($signed(top));
    cur_cols = cols == 0 ? 1 : (cols > 256 ? 256 : int'(cols));
    cur_rows = rows == 0 ? 1 : (rows > 256 ? 256 : int'(rows));
  endtask

  function automatic logic [31:0] near_grid(longint org, int n);
    return 32'(org + longint'($urandom_range(0, 32'((n + 2) * cur_cs))) - cur_cs);
  endfunction

  function automatic logic [31:0] pick_height();
    case ($urandom_range(0, 5))
      0: return 32'(cur_gnd - 1);
      1: return 32'(cur_gnd);
      2: return 32'(cur_top);
      3: return 32'(cur_top + 1);
      4: return $urandom;
      default: return 32'(cur_gnd + (cur_top - cur_gnd) / 2);
    endcase
  endfunction

  task automatic random_items(input int count, input bit noise);
    int sel;
    logic [23:0] e;
    for (int i = 0; i < count; i++) begin
      if (noise) begin
        send_item(2'($urandom), $urandom, $urandom, $urandom, 24'($urandom),
                  1'($urandom), 8'($urandom), 8'($urandom));
        continue;
      end
      sel = $urandom_range(0, 99);
      e = 24'($urandom_range(0, 32'(3 * cur_cs)));
      if (sel < 45) begin
        send_item(KIND_VOXEL, near_grid(cur_ox, cur_cols), near_grid(cur_oy, cur_rows),
                  pick_height(), e, 1'($urandom_range(0, 3) != 0), 8'($urandom), 8'($urandom));
      end else if (sel < 60) begin
        send_item(KIND_DISK, near_grid(cur_ox, cur_cols), near_grid(cur_oy, cur_rows),
                  $urandom, e, 1'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 96) begin
        send_item(KIND_READ, $urandom, $urandom, $urandom, 24'($urandom), 1'($urandom),
                  8'($urandom_range(0, cur_rows < 254 ? cur_rows + 1 : 255)),
                  8'($urandom_range(0, cur_cols < 254 ? cur_cols + 1 : 255)));
      end else begin
        send_item(KIND_NONE, $urandom, $urandom, $urandom, 24'($urandom), 1'($urandom),
                  8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_setting(32'd0, 32'd0, 16'd50, 32'd102, 32'd1024, 16'd2, 9'd256, 9'd256);
    send_item(KIND_READ, 0, 0, 0, 0, 1'b0, 8'd0, 8'd0);
    send_item(KIND_READ, 0, 0, 0, 0, 1'b0, 8'd255, 8'd255);
    send_item(KIND_VOXEL, 32'd25, 32'd25, 32'd500, 24'd10, 1'b1, 8'd0, 8'd0);
    send_item(KIND_VOXEL, 32'd25, 32'd25, 32'd1024, 24'd10, 1'b1, 8'd0, 8'd0);
    send_item(KIND_READ, 0, 0, 0, 0, 1'b0, 8'd0, 8'd0);
    send_item(KIND_VOXEL, 32'd75, 32'd25, 32'd500, 24'd0, 1'b0, 8'd0, 8'd0);
    send_item(KIND_READ, 0, 0, 0, 0, 1'b0, 8'd0, 8'd1);
    send_item(KIND_VOXEL, 32'd125, 32'd25, 32'd2000, 24'd0, 1'b1, 8'd0, 8'd0);
    send_item(KIND_VOXEL, 32'd125, 32'd75, 32'd101, 24'd0, 1'b1, 8'd0, 8'd0);
    send_item(KIND_VOXEL, 32'd125, 32'd75, 32'd102, 24'd0, 1'b1, 8'd0, 8'd0);
    send_item(KIND_READ, 0, 0, 0, 0, 1'b0, 8'd1, 8'd2);
    send_item(KIND_VOXEL, -32'sd100000, -32'sd5, 32'd500, 24'd3, 1'b1, 8'd0, 8'd0);
    send_item(KIND_VOXEL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 24'd0, 1'b1, 8'd0, 8'd0);
    send_item(KIND_VOXEL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 24'd0, 1'b1, 8'd0, 8'd0);
    send_item(KIND_READ, 0, 0, 0, 0, 1'b0, 8'd255, 8'd255);
    send_item(KIND_DISK, 32'd25, 32'd25, 0, 24'd0, 1'b0, 8'd0, 8'd0);
    send_item(KIND_DISK, 32'd75, 32'd125, 0, 24'd50, 1'b0, 8'd0, 8'd0);
    send_item(KIND_READ, 0, 0, 0, 0, 1'b0, 8'd0, 8'd0);
    send_item(KIND_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1,
              8'hFF, 8'hFF);
    send_item(KIND_VOXEL, 32'd0, 32'd0, 32'd0, 24'hFFFFFF, 1'b0, 8'd0, 8'd0);
    send_item(KIND_VOXEL, 32'd6400, 32'd6400, 32'd500, 24'hFFFFFF, 1'b1, 8'd0, 8'd0);
    send_item(KIND_DISK, 32'd0, 32'd0, 0, 24'hFFFFFF, 1'b0, 8'd0, 8'd0);
    send_item(KIND_READ, 0, 0, 0, 0, 1'b0, 8'd128, 8'd7);

    load_setting(32'd0, 32'd0, 16'd51, 32'd102, 32'd1024, 16'd2, 9'd256, 9'd256);
    random_items(300, 1'b0);
    load_setting(-32'sd1000, 32'd2000, 16'd1, -32'sd50, 32'd50, 16'd1, 9'd16, 9'd16);
    random_items(300, 1'b0);
    load_setting(32'h80000000, 32'h7FFF0000, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF,
                 16'd0, 9'd3, 9'd200);
    random_items(250, 1'b0);
    load_setting(32'd12345, -32'sd777, 16'd300, 32'd0, 32'd0, 16'hFFFF, 9'd256, 9'd1);
    random_items(250, 1'b0);
    load_setting($urandom, $urandom, 16'($urandom), $urandom, $urandom, 16'd1,
                 9'd5, 9'd5);
    random_items(200, 1'b1);
    load_setting(32'd0, 32'd0, 16'd0, 32'h7FFFFFFF, 32'h80000000, 16'd3, 9'd511, 9'd0);
    random_items(250, 1'b0);
    load_setting(-32'sd2048, -32'sd2048, 16'd40, -32'sd10, 32'd900, 16'd1, 9'd64, 9'd64);
    random_items(150, 1'b0);
    quiet = 1'b1;
    random_items(150, 1'b0);
    in_valid <= 1'b0;

    wait (pending_cnt == 0);
    repeat (400) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
